// ===== rtl/core/wfsp_pkg.sv =====
package wfsp_pkg;

   localparam int MAX_AREAS = 16;
   localparam int IDX_W     = $clog2(MAX_AREAS);
   localparam int CNT_W     = $clog2(MAX_AREAS + 1);

   localparam int MODE_W    = 2;
   localparam int DIRS_W    = 10;
   localparam int FREE_W    = 40;
   localparam int FRAC_W    = 32;
   localparam int RAND_W    = 31;
   localparam int STATUS_W  = 2;
   localparam int SLD_W     = 10;
   localparam int SPAN_W    = SLD_W + DIRS_W;
   localparam int TOTAL_W   = FREE_W + IDX_W;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_SEL_BIT = 3;

   localparam logic [FREE_W-1:0] THRESHOLD_RESET = FREE_W'(500);
   localparam logic [SLD_W-1:0]  SLD_RESET       = '0;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_PICK   = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_NOSPACE = 2'd2,
      ST_BADSLD  = 2'd3
   } status_type;

   typedef enum logic {
      REG_THRESHOLD = 1'b0,
      REG_SLD       = 1'b1
   } reg_sel_type;

   typedef struct packed {
      logic              clear;
      logic              append;
      logic [DIRS_W-1:0] dirs;
      logic [FREE_W-1:0] free_megs;
   } tbl_cmd_type;

   typedef struct packed {
      logic [FREE_W-1:0] weight;
      logic [DIRS_W-1:0] dirs;
   } tbl_rd_type;

endpackage

// ===== rtl/core/wfsp_if.sv =====
interface wfsp_req_if import wfsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [DIRS_W-1:0]   dir_count;
   logic [FREE_W-1:0]   free_megs;
   logic [FRAC_W-1:0]   rand_fraction;
   logic [RAND_W-1:0]   rand_value;

   modport source (output valid, mode, dir_count, free_megs, rand_fraction, rand_value,
                   input ready);
   modport sink   (input valid, mode, dir_count, free_megs, rand_fraction, rand_value,
                   output ready);
endinterface

interface wfsp_rsp_if import wfsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    entry_index;
   logic [DIRS_W-1:0]   high_dir;
   logic [SLD_W-1:0]    second_dir;

   modport source (output valid, status, entry_index, high_dir, second_dir, input ready);
   modport sink   (input valid, status, entry_index, high_dir, second_dir, output ready);
endinterface

// ===== rtl/core/weighted_free_space_picker_unit.sv =====
// clear and append: the unit stays idle, the next request is taken in the following cycle
// pick: a sum pass over the areas, a bit-serial multiply for the wheel point (32 steps),
// a scan to the chosen area and two 31-step serial divisions for the directory
// one pick at a time; a new request is taken while a result waits in the output register
// synchronous active-high reset empties the table, sets threshold 500 and
// second-level max 0
module weighted_free_space_picker_unit import wfsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wfsp_req_if.sink              req_chan,
   wfsp_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_SUM  = 8'b0000_0010,
      S_MULT = 8'b0000_0100,
      S_SCAN = 8'b0000_1000,
      S_SPAN = 8'b0001_0000,
      S_DIV1 = 8'b0010_0000,
      S_DIV2 = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [FREE_W-1:0]  thresh_ff, thresh_in;
   logic [SLD_W-1:0]   sld_ff, sld_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] run_ff, run_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [RAND_W-1:0]  rnd_ff, rnd_in;
   status_type         status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [DIRS_W-1:0]  rsp_high_ff, rsp_high_in;
   logic [SLD_W-1:0]   rsp_second_ff, rsp_second_in;

   logic               csr_wr;
   reg_sel_type        csr_sel;
   logic               req_ready;
   logic               req_accept;
   tbl_cmd_type        tbl_cmd;
   tbl_rd_type         tbl_rd;
   logic [CNT_W-1:0]   tbl_count;
   logic               last_entry;
   logic [TOTAL_W-1:0] sum_total;
   logic [TOTAL_W-1:0] sum_run;
   logic               hit;
   logic [SPAN_W-1:0]  span;

   logic               mul_start, mul_done;
   logic [TOTAL_W-1:0] point;
   logic               div_start, div_done;
   logic [RAND_W-1:0]  div_dividend, div_quo;
   logic [SPAN_W-1:0]  div_divisor, div_rem;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = reg_sel_type'(csr_paddr[CSR_SEL_BIT]);

   always_comb begin
      thresh_in = thresh_ff;
      sld_in    = sld_ff;
      if (csr_wr) begin
         case (csr_sel)
            REG_THRESHOLD: thresh_in = csr_pwdata[FREE_W-1:0];
            REG_SLD:       sld_in    = csr_pwdata[SLD_W-1:0];
            default:       thresh_in = thresh_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(thresh_ff);
         REG_SLD:       csr_prdata = CSR_DATA_W'(sld_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // request side
   assign req_ready      = (state_ff == S_IDLE);
   assign req_chan.ready = req_ready;
   assign req_accept     = req_chan.valid && req_ready;

   assign tbl_cmd.clear     = req_accept && (req_chan.mode == MODE_CLEAR);
   assign tbl_cmd.append    = req_accept && (req_chan.mode == MODE_APPEND);
   assign tbl_cmd.dirs      = req_chan.dir_count;
   assign tbl_cmd.free_megs = req_chan.free_megs;

   wfsp_area_table u_table (
      .clock     (clock),
      .reset     (reset),
      .cmd       (tbl_cmd),
      .threshold (thresh_ff),
      .rd_idx    (idx_ff),
      .rd        (tbl_rd),
      .count     (tbl_count)
   );

   wfsp_serial_mult u_mult (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .total (total_in),
      .frac  (frac_ff),
      .point (point),
      .done  (mul_done)
   );

   wfsp_serial_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == tbl_count);
   assign sum_total  = total_ff + TOTAL_W'(tbl_rd.weight);
   assign sum_run    = run_ff + TOTAL_W'(tbl_rd.weight);
   assign hit        = (sum_run > point);
   assign span       = SPAN_W'(sld_ff) * SPAN_W'(tbl_rd.dirs);

   // first division gives rand mod span, second splits it by second-level max
   assign div_dividend = (state_ff == S_SPAN) ? rnd_ff : RAND_W'(div_rem);
   assign div_divisor  = (state_ff == S_SPAN) ? span : SPAN_W'(sld_ff);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      total_in      = total_ff;
      run_in        = run_ff;
      frac_in       = frac_ff;
      rnd_in        = rnd_ff;
      status_in     = status_ff;
      mul_start     = 1'b0;
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_second_in = rsp_second_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_chan.mode == MODE_PICK) begin
               frac_in  = req_chan.rand_fraction;
               rnd_in   = req_chan.rand_value;
               idx_in   = '0;
               total_in = '0;
               if (tbl_count == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            total_in = sum_total;
            idx_in   = idx_ff + IDX_W'(1);
            if (last_entry) begin
               idx_in = '0;
               run_in = '0;
               if (sum_total == '0) begin
                  status_in = ST_NOSPACE;
                  state_in  = S_DONE;
               end else if (sld_ff == '0) begin
                  status_in = ST_BADSLD;
                  state_in  = S_DONE;
               end else begin
                  mul_start = 1'b1;
                  state_in  = S_MULT;
               end
            end
         end
         S_MULT: begin
            if (mul_done) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            run_in = sum_run;
            if (hit || last_entry) begin
               state_in = S_SPAN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_SPAN: begin
            div_start = 1'b1;
            state_in  = S_DIV1;
         end
         S_DIV1: begin
            if (div_done) begin
               div_start = 1'b1;
               state_in  = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_done) begin
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_idx_in    = '0;
               rsp_high_in   = '0;
               rsp_second_in = '0;
               if (status_ff == ST_OK) begin
                  rsp_idx_in    = idx_ff;
                  rsp_high_in   = div_quo[DIRS_W-1:0];
                  rsp_second_in = div_rem[SLD_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESHOLD_RESET;
         sld_ff       <= SLD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
         sld_ff       <= sld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      total_ff      <= total_in;
      run_ff        <= run_in;
      frac_ff       <= frac_in;
      rnd_ff        <= rnd_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_index = rsp_idx_ff;
   assign rsp_chan.high_dir    = rsp_high_ff;
   assign rsp_chan.second_dir  = rsp_second_ff;

`ifndef ASSERT_OFF
   // the wheel point lies below the total, so the scan must land by the last entry
   a_scan_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && last_entry) |-> hit)
      else $error("scan reached last entry without passing the point");

   // a pick always leaves idle, other requests never do
   a_pick_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ((state_ff != S_IDLE) == ($past(req_chan.mode) == MODE_PICK)))
      else $error("state after request does not match its mode");

   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      tbl_count <= CNT_W'(MAX_AREAS))
      else $error("area count above table depth");

   a_second_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_OK) |-> (rsp_second_ff < sld_ff))
      else $error("second-level directory out of range");
`endif

endmodule

// ===== rtl/core/wfsp_area_table.sv =====
module wfsp_area_table import wfsp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  tbl_cmd_type       cmd,
   input  logic [FREE_W-1:0] threshold,
   input  logic [IDX_W-1:0]  rd_idx,
   output tbl_rd_type        rd,
   output logic [CNT_W-1:0]  count
);

   logic [DIRS_W-1:0] dirs_ff [MAX_AREAS];
   logic [FREE_W-1:0] free_ff [MAX_AREAS];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              room;

   assign room = (count_ff < CNT_W'(MAX_AREAS));

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append && room) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && !cmd.clear && room) begin
         dirs_ff[count_ff[IDX_W-1:0]] <= cmd.dirs;
         free_ff[count_ff[IDX_W-1:0]] <= cmd.free_megs;
      end
   end

   // areas under the threshold or without directories weigh nothing
   always_comb begin
      rd.dirs   = dirs_ff[rd_idx];
      rd.weight = '0;
      if (free_ff[rd_idx] >= threshold && dirs_ff[rd_idx] != '0) begin
         rd.weight = free_ff[rd_idx];
      end
   end

   assign count = count_ff;

endmodule

// ===== rtl/core/wfsp_serial_mult.sv =====
module wfsp_serial_mult import wfsp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] total,
   input  logic [FRAC_W-1:0]  frac,
   output logic [TOTAL_W-1:0] point,
   output logic               done
);

   localparam int STEP_W = $clog2(FRAC_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_W - 1);

   logic [TOTAL_W-1:0] acc_ff,   acc_in;
   logic [TOTAL_W-1:0] mcand_ff, mcand_in;
   logic [FRAC_W-1:0]  frac_ff,  frac_in;
   logic [STEP_W-1:0]  step_ff,  step_in;
   logic               busy_ff,  busy_in;
   logic               done_ff,  done_in;
   logic [TOTAL_W:0]   sum;

   // lsb first: add the multiplicand, drop the bit that falls below 2^-32
   assign sum = {1'b0, acc_ff} + (frac_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = '0;
         mcand_in = total;
         frac_in  = frac;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in  = sum[TOTAL_W:1];
         frac_in = frac_ff >> 1;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      frac_ff  <= frac_in;
      step_ff  <= step_in;
   end

   assign point = acc_ff;
   assign done  = done_ff;

endmodule

// ===== rtl/core/wfsp_serial_div.sv =====
module wfsp_serial_div import wfsp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAND_W-1:0] dividend,
   input  logic [SPAN_W-1:0] divisor,
   output logic [RAND_W-1:0] quotient,
   output logic [SPAN_W-1:0] remainder,
   output logic              done
);

   localparam int STEP_W = $clog2(RAND_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RAND_W - 1);

   logic [RAND_W-1:0] quo_ff,  quo_in;
   logic [SPAN_W-1:0] rem_ff,  rem_in;
   logic [SPAN_W-1:0] den_ff,  den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SPAN_W:0]   trial;
   logic              fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[RAND_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[RAND_W-2:0], fits};
         rem_in  = fits ? SPAN_W'(trial - {1'b0, den_ff}) : trial[SPAN_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== tb/wfsp_pick_checker.sv =====
module wfsp_pick_checker import wfsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wfsp_req_if                   req_mon,
   wfsp_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending_picks,
   output int                    picks_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type        status;
      logic [IDX_W-1:0]  entry_index;
      logic [DIRS_W-1:0] high_dir;
      logic [SLD_W-1:0]  second_dir;
   } pick_outcome_type;

   // shadow copy of the area table and registers
   logic [FREE_W-1:0] thr_reg;
   logic [SLD_W-1:0]  sld_reg;
   logic [DIRS_W-1:0] tbl_dirs [MAX_AREAS];
   logic [FREE_W-1:0] tbl_free [MAX_AREAS];
   int                tbl_fill;
   pick_outcome_type  expected_picks [$];

   function automatic logic [FREE_W-1:0] area_weight(int i);
      if (tbl_free[i] < thr_reg || tbl_dirs[i] == '0) return '0;
      return tbl_free[i];
   endfunction

   function automatic pick_outcome_type predict_pick(logic [FRAC_W-1:0] frac,
                                                     logic [RAND_W-1:0] rnd);
      pick_outcome_type  o;
      logic [63:0]       total;
      logic [63:0]       running;
      logic [63:0]       point;
      logic [95:0]       prod;
      logic [SPAN_W-1:0] span;
      logic [RAND_W-1:0] target;
      int                chosen;
      o = '0;
      o.status = ST_OK;
      if (tbl_fill == 0) begin
         o.status = ST_EMPTY;
         return o;
      end
      total = '0;
      for (int i = 0; i < tbl_fill; i++) total += area_weight(i);
      if (total == '0) begin
         o.status = ST_NOSPACE;
         return o;
      end
      // wheel point is floor(total * frac / 2^32), exact
      prod = total * frac;
      point = prod[95:32];
      chosen = 0;
      running = '0;
      for (int i = 0; i < tbl_fill; i++) begin
         running += area_weight(i);
         if (running > point) begin
            chosen = i;
            break;
         end
      end
      if (sld_reg == '0) begin
         o.status = ST_BADSLD;
         return o;
      end
      span = sld_reg * tbl_dirs[chosen];
      target = rnd % span;
      o.entry_index = chosen[IDX_W-1:0];
      o.high_dir = DIRS_W'(target / sld_reg);
      o.second_dir = SLD_W'(target % sld_reg);
      return o;
   endfunction

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      $display("%0t: pick %0d %s mismatch, expected %0d, got %0d",
               $time, picks_checked, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      pick_outcome_type want;
      if (reset) begin
         thr_reg = THRESHOLD_RESET;
         sld_reg = SLD_RESET;
         tbl_fill = 0;
         expected_picks.delete();
         pending_picks = 0;
         fail_count = 0;
         picks_checked = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_sel_type'(csr_paddr[CSR_SEL_BIT]))
               REG_THRESHOLD: thr_reg = csr_pwdata[FREE_W-1:0];
               REG_SLD:       sld_reg = csr_pwdata[SLD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_picks.size() == 0) begin
               report_mismatch("unrequested result, status", 0, rsp_mon.status);
            end else begin
               want = expected_picks.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", want.status, rsp_mon.status);
               if (rsp_mon.entry_index !== want.entry_index)
                  report_mismatch("entry_index", want.entry_index, rsp_mon.entry_index);
               if (rsp_mon.high_dir !== want.high_dir)
                  report_mismatch("high_dir", want.high_dir, rsp_mon.high_dir);
               if (rsp_mon.second_dir !== want.second_dir)
                  report_mismatch("second_dir", want.second_dir, rsp_mon.second_dir);
               picks_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.mode)
               MODE_CLEAR: tbl_fill = 0;
               MODE_APPEND: begin
                  if (tbl_fill < MAX_AREAS) begin
                     tbl_dirs[tbl_fill] = req_mon.dir_count;
                     tbl_free[tbl_fill] = req_mon.free_megs;
                     tbl_fill++;
                  end
               end
               MODE_PICK: begin
                  expected_picks.push_back(predict_pick(req_mon.rand_fraction,
                                                        req_mon.rand_value));
               end
               default: ;
            endcase
         end
         pending_picks = expected_picks.size();
      end
   end

endmodule

// ===== tb/tb_weighted_free_space_picker_unit.sv =====
module tb_weighted_free_space_picker_unit import wfsp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                CYCLE_LIMIT   = 500000;
   localparam int                SETTLE_CYCLES = 200;
   localparam int                SEG_ITEMS     = 57;
   localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;
   localparam logic [FREE_W-1:0] FREE_MAX      = '1;
   localparam logic [FRAC_W-1:0] FRAC_MAX      = '1;
   localparam logic [RAND_W-1:0] RAND_MAX      = '1;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  sink_ready = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycles = 0;
   int fail_count;
   int pending_picks;
   int picks_checked;
   int tb_fill = 0;
   int sent_items = 0;
   int settings_applied = 0;
   logic [FREE_W-1:0] cur_thr = THRESHOLD_RESET;

   wfsp_req_if req_chan ();
   wfsp_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   weighted_free_space_picker_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   wfsp_pick_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_picks (pending_picks),
      .picks_checked (picks_checked)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(negedge clock) sink_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d picks outstanding", cycles, pending_picks);
         $display("weighted_free_space_picker_unit verification failed");
         $finish;
      end
   end

   function automatic logic [FREE_W-1:0] rand_free();
      logic [FREE_W-1:0] v;
      case ($urandom_range(7))
         0: v = '0;
         1: v = FREE_MAX;
         2: v = cur_thr;
         3: v = (cur_thr == '0) ? '0 : cur_thr - 1'b1;
         4: v = FREE_W'({$urandom, $urandom});
         default: begin
            if (cur_thr > FREE_MAX - 8192) v = FREE_MAX;
            else v = cur_thr + FREE_W'($urandom_range(8191));
         end
      endcase
      return v;
   endfunction

   function automatic logic [DIRS_W-1:0] rand_dirs();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return DIRS_W'(1);
         3: return DIRS_W'($urandom);
         default: return DIRS_W'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic logic [FRAC_W-1:0] rand_frac();
      case ($urandom_range(7))
         0: return '0;
         1: return FRAC_MAX;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [RAND_W-1:0] rand_rnd();
      case ($urandom_range(7))
         0: return '0;
         1: return RAND_MAX;
         default: return RAND_W'($urandom);
      endcase
   endfunction

   // entered and left at a falling edge; valid stays high after acceptance
   task automatic send_request(logic [MODE_W-1:0] mode, logic [DIRS_W-1:0] dirs,
                               logic [FREE_W-1:0] free_val, logic [FRAC_W-1:0] frac,
                               logic [RAND_W-1:0] rnd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.mode = mode;
      req_chan.dir_count = dirs;
      req_chan.free_megs = free_val;
      req_chan.rand_fraction = frac;
      req_chan.rand_value = rnd;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
      if (mode == MODE_CLEAR) begin
         tb_fill = 0;
      end else if (mode == MODE_APPEND) begin
         if (tb_fill < MAX_AREAS) tb_fill++;
      end
      @(negedge clock);
   endtask

   task automatic append_area(logic [DIRS_W-1:0] dirs, logic [FREE_W-1:0] free_val);
      send_request(MODE_APPEND, dirs, free_val, $urandom, RAND_W'($urandom));
   endtask

   task automatic pick_area(logic [FRAC_W-1:0] frac, logic [RAND_W-1:0] rnd);
      send_request(MODE_PICK, DIRS_W'($urandom), FREE_W'({$urandom, $urandom}), frac, rnd);
   endtask

   task automatic csr_write(reg_sel_type sel, logic [CSR_DATA_W-1:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = '0;
      csr_paddr[CSR_SEL_BIT] = sel;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic set_registers(logic [FREE_W-1:0] thr, logic [SLD_W-1:0] sld);
      csr_write(REG_THRESHOLD, CSR_DATA_W'(thr));
      csr_write(REG_SLD, CSR_DATA_W'(sld));
      cur_thr = thr;
      settings_applied++;
   endtask

   // drain every pick, then leave room for a clear or append still in flight
   task automatic settle();
      req_chan.valid = 1'b0;
      while (pending_picks != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_directed();
      pick_area('0, '0);                       // empty table
      append_area('0, FREE_MAX);               // no directories
      append_area('1, 40'd499);                // just under threshold
      pick_area(FRAC_MAX, RAND_MAX);           // nothing eligible
      send_request(MODE_UNUSED, '1, FREE_MAX, FRAC_MAX, RAND_MAX);
      append_area(DIRS_W'(3), 40'd500);        // exactly at threshold
      pick_area($urandom, RAND_W'($urandom));  // second-level max still zero
      settle();
      set_registers('0, SLD_W'(1));
      pick_area('0, '0);                       // zero-weight head is skipped
      pick_area(FRAC_MAX, RAND_MAX);
      settle();
      set_registers(FREE_MAX, '1);
      append_area('1, FREE_MAX);
      pick_area($urandom, RAND_MAX);
      while (tb_fill < MAX_AREAS) append_area(rand_dirs(), rand_free());
      append_area('1, FREE_MAX);               // table full, dropped
      pick_area(rand_frac(), rand_rnd());
      send_request(MODE_CLEAR, '1, FREE_MAX, FRAC_MAX, RAND_MAX);
      pick_area(FRAC_MAX, RAND_MAX);
   endtask

   task automatic apply_setting(int idx);
      case (idx)
         0: set_registers('0, SLD_W'(1));
         1: set_registers(THRESHOLD_RESET, '1);
         2: set_registers(FREE_MAX, SLD_W'($urandom_range(1, 1023)));
         default: begin
            set_registers(FREE_W'($urandom_range(4096)),
                          ($urandom_range(15) == 0) ? '0 : SLD_W'($urandom_range(1, 1023)));
         end
      endcase
   endtask

   task automatic run_segment(int n);
      int goal;
      int k;
      goal = sent_items + n;
      while (sent_items < goal) begin
         if ($urandom_range(9) == 0) begin
            // noise: any mode, any field
            send_request(MODE_W'($urandom), DIRS_W'($urandom), FREE_W'({$urandom, $urandom}),
                         $urandom, RAND_W'($urandom));
         end else begin
            if ($urandom_range(2) == 0 || tb_fill == MAX_AREAS)
               send_request(MODE_CLEAR, DIRS_W'($urandom), FREE_W'({$urandom, $urandom}),
                            $urandom, RAND_W'($urandom));
            k = ($urandom_range(7) == 0) ? MAX_AREAS + 1 : $urandom_range(1, 6);
            repeat (k) append_area(rand_dirs(), rand_free());
            k = $urandom_range(1, 5);
            repeat (k) pick_area(rand_frac(), rand_rnd());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_CLEAR;
      req_chan.dir_count = '0;
      req_chan.free_megs = '0;
      req_chan.rand_fraction = '0;
      req_chan.rand_value = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            settle();
            apply_setting(phase * 3 + seg);
            run_segment(SEG_ITEMS);
         end
      end
      settle();
      $display("covered %0d requests (clear, append, pick, full table, unused mode)",
               sent_items);
      $display("%0d picks compared across %0d register settings and three stall mixes",
               picks_checked, settings_applied);
      if (fail_count == 0) begin
         $display("weighted_free_space_picker_unit verification clean");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("weighted_free_space_picker_unit verification failed");
      end
      $finish;
   end

endmodule
